// File: design/port_hotplug_liveness_monitor_macros.svh
// Assertion macros for the hot-plug and liveness monitor.
`ifndef PORT_HOTPLUG_LIVENESS_MONITOR_MACROS_SVH
`define PORT_HOTPLUG_LIVENESS_MONITOR_MACROS_SVH

// Same-cycle implication, masked during reset.
`define PHLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define PHLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/phlm_pkg.sv
// Shared constants and types of the hot-plug and liveness monitor.
package phlm_pkg;

   localparam int NUM_PORTS  = 8;
   localparam int PORT_W     = 3;
   localparam int TIME_W     = 32;
   localparam int DEBOUNCE_W = 16;
   localparam int TIMEOUT_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd10;
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 16'd500;
   localparam logic [NUM_PORTS-1:0]  ENABLE_RESET   = '1;

   localparam logic OP_SCAN      = 1'b0;
   localparam logic OP_FRAME     = 1'b1;
   localparam logic EVT_INSERT   = 1'b0;
   localparam logic EVT_REMOVE   = 1'b1;
   localparam logic ORIENT_UP    = 1'b0;
   localparam logic ORIENT_RIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce;
      logic [TIMEOUT_W-1:0]  timeout;
      logic [NUM_PORTS-1:0]  enable;
   } cfg_type;

   // Classified word as it travels from front to back.
   typedef struct packed {
      logic              is_frame;
      logic [PORT_W-1:0] port;
      logic [TIME_W-1:0] now;
      logic              pin_a;
      logic              pin_b;
      logic              one_high;
      logic              new_orient;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qword_type;

   typedef struct packed {
      logic pop;
      logic has_result;
   } back_status_type;

endpackage

// File: design/phlm_req_if.sv
// Request channel interface: scan and frame-heard words.
interface phlm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [phlm_pkg::PORT_W-1:0] port_index;
   logic [phlm_pkg::TIME_W-1:0] now_ms;
   logic                        pin_a_level;
   logic                        pin_b_level;

   modport source (output valid, opcode, port_index, now_ms, pin_a_level, pin_b_level,
                   input ready);
   modport sink   (input valid, opcode, port_index, now_ms, pin_a_level, pin_b_level,
                   output ready);
endinterface

// File: design/phlm_rsp_if.sv
// Response channel interface: insert and remove events.
interface phlm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        event_kind;
   logic [phlm_pkg::PORT_W-1:0] event_port;
   logic                        event_orientation;

   modport source (output valid, event_kind, event_port, event_orientation, input ready);
   modport sink   (input valid, event_kind, event_port, event_orientation, output ready);
endinterface

// File: design/phlm_csr_if.sv
// Configuration write channel interface.
interface phlm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [phlm_pkg::CSR_IDX_W-1:0]  index;
   logic [phlm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: design/phlm_queue.sv
// Short FIFO between the front end and the back end.
module phlm_queue (
   input  logic                clock,
   input  logic                reset,
   input  phlm_pkg::qword_type push,
   input  logic                pop,
   output logic                full,
   output phlm_pkg::qword_type head
);

   phlm_pkg::item_type                   entries_ff [phlm_pkg::QUEUE_DEPTH];
   logic [phlm_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [phlm_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [phlm_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == phlm_pkg::QUEUE_CNT_W'(phlm_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == phlm_pkg::QUEUE_PTR_W'(phlm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + phlm_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == phlm_pkg::QUEUE_PTR_W'(phlm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + phlm_pkg::QUEUE_PTR_W'(1);
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + phlm_pkg::QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - phlm_pkg::QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/phlm_front.sv
// Front end: accepts request words and classifies them for the back end.
module phlm_front (
   phlm_req_if.sink             req_chan,
   input  logic                 q_full,
   output phlm_pkg::qword_type  push
);

   assign req_chan.ready = !q_full;

   always_comb begin
      push.valid           = req_chan.valid && !q_full;
      push.item.is_frame   = (req_chan.opcode == phlm_pkg::OP_FRAME);
      push.item.port       = req_chan.port_index;
      push.item.now        = req_chan.now_ms;
      push.item.pin_a      = req_chan.pin_a_level;
      push.item.pin_b      = req_chan.pin_b_level;
      // exactly one high pin is a candidate insertion; that pin receives
      push.item.one_high   = req_chan.pin_a_level ^ req_chan.pin_b_level;
      push.item.new_orient = req_chan.pin_a_level ? phlm_pkg::ORIENT_UP
                                                  : phlm_pkg::ORIENT_RIGHT;
   end

endmodule

// File: design/phlm_back.sv
// Back end: per-port state update, event decision and response register.
module phlm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  phlm_pkg::cfg_type         cfg,
   input  phlm_pkg::qword_type       head,
   output phlm_pkg::back_status_type status,
   phlm_rsp_if.source                rsp_chan
);

   logic                        configured_ff  [phlm_pkg::NUM_PORTS];
   logic                        configured_in  [phlm_pkg::NUM_PORTS];
   logic                        orient_ff      [phlm_pkg::NUM_PORTS];
   logic                        orient_in      [phlm_pkg::NUM_PORTS];
   logic [phlm_pkg::TIME_W-1:0] detect_time_ff [phlm_pkg::NUM_PORTS];
   logic [phlm_pkg::TIME_W-1:0] detect_time_in [phlm_pkg::NUM_PORTS];
   logic [phlm_pkg::TIME_W-1:0] heard_time_ff  [phlm_pkg::NUM_PORTS];
   logic [phlm_pkg::TIME_W-1:0] heard_time_in  [phlm_pkg::NUM_PORTS];
   logic [phlm_pkg::TIME_W-1:0] rx_time_ff     [phlm_pkg::NUM_PORTS];
   logic [phlm_pkg::TIME_W-1:0] rx_time_in     [phlm_pkg::NUM_PORTS];

   logic                        out_valid_ff, out_valid_in;
   logic                        out_kind_ff, out_kind_in;
   logic [phlm_pkg::PORT_W-1:0] out_port_ff, out_port_in;
   logic                        out_orient_ff, out_orient_in;

   phlm_pkg::item_type          it;
   logic [phlm_pkg::TIME_W-1:0] since_detect, since_heard, since_rx;
   logic                        is_conf, rx_high, detect, remove, has_result, pop;

   assign it           = head.item;
   assign is_conf      = configured_ff[it.port];
   assign since_detect = it.now - detect_time_ff[it.port];
   assign since_heard  = it.now - heard_time_ff[it.port];
   assign since_rx     = it.now - rx_time_ff[it.port];
   assign rx_high      = orient_ff[it.port] ? it.pin_b : it.pin_a;

   assign detect = !it.is_frame && !is_conf && cfg.enable[it.port] && it.one_high &&
                   (since_detect >= phlm_pkg::TIME_W'(cfg.debounce));
   // a high rx pin refreshes the idle time to now, so removal cannot fire then
   assign remove = !it.is_frame && is_conf && !rx_high &&
                   (since_heard > phlm_pkg::TIME_W'(cfg.timeout)) &&
                   (since_rx > phlm_pkg::TIME_W'(cfg.timeout));

   assign has_result = head.valid && (detect || remove);
   // words without an event pass even while a result waits
   assign pop        = head.valid && (!out_valid_ff || rsp_chan.ready || !has_result);

   assign status.pop        = pop;
   assign status.has_result = has_result;

   always_comb begin
      configured_in  = configured_ff;
      orient_in      = orient_ff;
      detect_time_in = detect_time_ff;
      heard_time_in  = heard_time_ff;
      rx_time_in     = rx_time_ff;
      if (pop) begin
         if (it.is_frame) begin
            heard_time_in[it.port] = it.now;
         end else if (detect) begin
            configured_in[it.port]  = 1'b1;
            orient_in[it.port]      = it.new_orient;
            detect_time_in[it.port] = it.now;
            heard_time_in[it.port]  = it.now;
            rx_time_in[it.port]     = it.now;
         end else if (remove) begin
            configured_in[it.port] = 1'b0;
            heard_time_in[it.port] = '0;
            rx_time_in[it.port]    = '0;
         end else if (is_conf && rx_high) begin
            rx_time_in[it.port] = it.now;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_kind_in   = out_kind_ff;
      out_port_in   = out_port_ff;
      out_orient_in = out_orient_ff;
      if (pop && has_result) begin
         out_valid_in  = 1'b1;
         out_kind_in   = detect ? phlm_pkg::EVT_INSERT : phlm_pkg::EVT_REMOVE;
         out_port_in   = it.port;
         out_orient_in = detect ? it.new_orient : phlm_pkg::ORIENT_UP;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff   <= out_kind_in;
      out_port_ff   <= out_port_in;
      out_orient_ff <= out_orient_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < phlm_pkg::NUM_PORTS; i++) begin
            configured_ff[i]  <= 1'b0;
            orient_ff[i]      <= phlm_pkg::ORIENT_UP;
            detect_time_ff[i] <= '0;
            heard_time_ff[i]  <= '0;
            rx_time_ff[i]     <= '0;
         end
      end else begin
         out_valid_ff   <= out_valid_in;
         configured_ff  <= configured_in;
         orient_ff      <= orient_in;
         detect_time_ff <= detect_time_in;
         heard_time_ff  <= heard_time_in;
         rx_time_ff     <= rx_time_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.event_kind        = out_kind_ff;
   assign rsp_chan.event_port        = out_port_ff;
   assign rsp_chan.event_orientation = out_orient_ff;

endmodule

// File: design/port_hotplug_liveness_monitor.sv
// Top level of the per-port hot-plug and liveness monitor.
// Path: an accepted word is written into the queue; the back end then updates the
// port from the queue head and loads the event register, which drives the response.
// Throughput: one word per cycle; a word with an event waits while the last event is not yet taken.
// Reset (synchronous): debounce 10, timeout 500, all ports enabled, all port state
// and the queue cleared.
`include "port_hotplug_liveness_monitor_macros.svh"

module port_hotplug_liveness_monitor (
   input  logic        clock,
   input  logic        reset,
   phlm_req_if.sink    req_chan,
   phlm_rsp_if.source  rsp_chan,
   phlm_csr_if.sink    csr_chan
);

   logic [phlm_pkg::DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [phlm_pkg::TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [phlm_pkg::NUM_PORTS-1:0]  enable_ff, enable_in;

   phlm_pkg::cfg_type         cfg;
   phlm_pkg::qword_type       q_push;
   phlm_pkg::qword_type       q_head;
   phlm_pkg::back_status_type back_status;
   logic                      q_full;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      timeout_in  = timeout_ff;
      enable_in   = enable_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            phlm_pkg::CSR_DEBOUNCE: debounce_in = csr_chan.data[phlm_pkg::DEBOUNCE_W-1:0];
            phlm_pkg::CSR_TIMEOUT:  timeout_in  = csr_chan.data[phlm_pkg::TIMEOUT_W-1:0];
            phlm_pkg::CSR_ENABLE:   enable_in   = csr_chan.data[phlm_pkg::NUM_PORTS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= phlm_pkg::DEBOUNCE_RESET;
         timeout_ff  <= phlm_pkg::TIMEOUT_RESET;
         enable_ff   <= phlm_pkg::ENABLE_RESET;
      end else begin
         debounce_ff <= debounce_in;
         timeout_ff  <= timeout_in;
         enable_ff   <= enable_in;
      end
   end

   assign cfg.debounce = debounce_ff;
   assign cfg.timeout  = timeout_ff;
   assign cfg.enable   = enable_ff;

   phlm_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (q_push)
   );

   phlm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .pop   (back_status.pop),
      .full  (q_full),
      .head  (q_head)
   );

   phlm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head     (q_head),
      .status   (back_status),
      .rsp_chan (rsp_chan)
   );

   `PHLM_ASSERT_NOW(a_full_blocks_req, clock, reset, q_full, !req_chan.ready, "queue full but request ready")
   `PHLM_ASSERT_NOW(a_pop_needs_word, clock, reset, back_status.pop, q_head.valid, "pop from empty queue")
   `PHLM_ASSERT_NEXT(a_result_lands, clock, reset, back_status.pop && back_status.has_result, rsp_chan.valid, "event lost after pop")
   `PHLM_ASSERT_NOW(a_remove_orient_up, clock, reset, rsp_chan.valid && (rsp_chan.event_kind == phlm_pkg::EVT_REMOVE), rsp_chan.event_orientation == phlm_pkg::ORIENT_UP, "remove event with orientation set")

endmodule
